>>> rtl/spt_pkg.sv
// Shared types and constants of the SYN probe tracker.
`timescale 1ns / 1ps
package spt_pkg;

	localparam logic [2:0] KIND_PROBE    = 3'd0;
	localparam logic [2:0] KIND_SYNACK   = 3'd1;
	localparam logic [2:0] KIND_RST      = 3'd2;
	localparam logic [2:0] KIND_TIMEOUT  = 3'd3;
	localparam logic [2:0] KIND_FINISHED = 3'd4;

	localparam logic [7:0] FLAG_SYN = 8'h02;
	localparam logic [7:0] FLAG_RST = 8'h04;
	localparam logic [7:0] FLAG_ACK = 8'h10;

	localparam logic [2:0] REG_LOCAL_PORT  = 3'd0;
	localparam logic [2:0] REG_REMOTE_PORT = 3'd1;
	localparam logic [2:0] REG_PROBE_LIMIT = 3'd2;
	localparam logic [2:0] REG_TIMEOUT     = 3'd3;
	localparam logic [2:0] REG_INTERVAL    = 3'd4;

	localparam logic [31:0] SEQ_START = 32'd1000;
	localparam logic [47:0] TIME_MAX  = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        command;
		logic [47:0] now_ns;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] ack;
		logic [7:0]  flags;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] sequence_res;
		logic [47:0] rtt_ns;
		logic [31:0] sent_total;
		logic [31:0] received_total;
		logic [6:0]  loss_percent;
		logic        last;
	} result_t;

endpackage

>>> rtl/spt_queue.sv
// Short item queue between the front and the back of the tracker.
`timescale 1ns / 1ps
module spt_queue
	import spt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output item_t out_item
);
	item_t      mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_item  = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

>>> rtl/spt_front.sv
// Input stage: takes items and drops replies that can never match.
`timescale 1ns / 1ps
module spt_front
	import spt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_valid,
	output logic        s_ready,
	input  item_t       s_item,
	input  logic [15:0] local_port,
	input  logic [15:0] remote_port,
	output logic        q_valid,
	input  logic        q_ready,
	output item_t       q_item
);
	logic  valid_s1;
	item_t item_s1;
	logic  keep;

	assign s_ready = !valid_s1 || q_ready;
	assign q_valid = valid_s1;
	assign q_item  = item_s1;
	assign keep = !s_item.command ||
		((s_item.dst_port == local_port) && (s_item.src_port == remote_port) &&
		 (((s_item.flags & FLAG_SYN) != 8'd0 && (s_item.flags & FLAG_ACK) != 8'd0) ||
		  (s_item.flags & FLAG_RST) != 8'd0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_ready) begin
			valid_s1 <= s_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (s_ready) item_s1 <= s_item;
	end
endmodule

>>> rtl/spt_back.sv
// Execution engine: probes, timeout sweep, replies and finish report.
`timescale 1ns / 1ps
module spt_back
	import spt_pkg::*;
#(
	parameter int INDEX_BITS = 10,
	parameter int MAX_SWEEP  = 62
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  item_t       q_item,
	input  logic [31:0] probe_limit,
	input  logic [47:0] timeout_val,
	input  logic [47:0] interval_val,
	output logic        busy,
	output logic        m_valid,
	input  logic        m_ready,
	output result_t     m_res
);
	localparam int DEPTH = 1 << INDEX_BITS;
	localparam int SW = $clog2(MAX_SWEEP + 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PROBE, S_SW_RD, S_SW_WAIT, S_SW_TEST, S_FIN,
		S_RP_RD, S_RP_WAIT, S_RP_TEST, S_LOSS, S_EMIT
	} state_t;

	state_t state_q, ret_q;
	item_t  it_q;

	logic [47:0] st_mem [DEPTH];
	logic        rf_mem [DEPTH];
	logic [47:0] st_rd_q;
	logic        rf_rd_q;

	logic [INDEX_BITS-1:0] clr_q, sweep_q, idx_q;
	logic [31:0] next_seq_q, sent_q, recv_q;
	logic [47:0] next_send_q;
	logic        fin_q;
	logic [SW-1:0] tcnt_q;

	logic [INDEX_BITS-1:0] rd_addr;
	logic        st_we, rf_we, rf_wd;
	logic [INDEX_BITS-1:0] wr_addr;
	logic [47:0] st_wd;

	result_t res_q;
	logic    pend_q;
	logic    out_v_q;
	result_t out_q;

	logic [38:0] num_q;
	logic [31:0] den_q;
	logic [6:0]  quo_q;
	logic [2:0]  lcnt_q;

	logic [48:0] exp_sum, nxt_sum;
	logic [31:0] ack_m1;
	logic [INDEX_BITS-1:0] next_idx;
	logic        limit_ok, limit_hit;
	logic [38:0] trial;
	logic        fin_now;
	logic        out_set;

	assign next_idx = next_seq_q[INDEX_BITS-1:0];
	assign exp_sum  = {1'b0, st_rd_q} + {1'b0, timeout_val};
	assign nxt_sum  = {1'b0, it_q.now_ns} + {1'b0, interval_val};
	assign ack_m1   = (it_q.ack != 32'd0) ? it_q.ack - 32'd1 : 32'd0;
	assign limit_ok = (probe_limit == 32'd0) || (sent_q < probe_limit);
	assign limit_hit = (probe_limit != 32'd0) && (sent_q >= probe_limit);
	assign trial = {den_q, 7'd0};
	assign fin_now = limit_hit && (sweep_q == next_idx);

	// A result whose successor is not yet known waits in the output register as pending.
	assign out_set = ((state_q == S_EMIT) &&
		(pend_q || ((!out_v_q || m_ready) && (ret_q == S_IDLE)))) ||
		((state_q == S_FIN) && pend_q && !fin_now);

	assign q_ready = (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE) || out_v_q;
	assign m_valid = out_v_q;
	assign m_res   = out_q;

	always_comb begin
		rd_addr = (state_q == S_RP_RD || state_q == S_RP_WAIT) ?
			ack_m1[INDEX_BITS-1:0] : sweep_q;
		st_we = 1'b0;
		rf_we = 1'b0;
		rf_wd = 1'b0;
		wr_addr = idx_q;
		st_wd = it_q.now_ns;
		unique case (state_q)
			S_CLEAR: begin
				st_we = 1'b1; rf_we = 1'b1; wr_addr = clr_q; st_wd = 48'd0;
			end
			S_PROBE: begin
				st_we = 1'b1; rf_we = 1'b1; wr_addr = next_idx;
			end
			S_SW_TEST: begin
				if (!rf_rd_q && it_q.now_ns >= exp_sum[47:0] && !exp_sum[48] &&
				    tcnt_q < SW'(MAX_SWEEP)) begin
					rf_we = 1'b1; rf_wd = 1'b1; wr_addr = sweep_q;
				end else if (!rf_rd_q && !exp_sum[48] && it_q.now_ns >= exp_sum[47:0]) begin
					rf_we = 1'b0;
				end
			end
			S_RP_TEST: begin
				if (!rf_rd_q) begin
					rf_we = 1'b1; rf_wd = 1'b1; wr_addr = ack_m1[INDEX_BITS-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) st_mem[wr_addr] <= st_wd;
		if (rf_we) rf_mem[wr_addr] <= rf_wd;
		st_rd_q <= st_mem[rd_addr];
		rf_rd_q <= rf_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ret_q <= S_IDLE;
			clr_q <= '0;
			sweep_q <= SEQ_START[INDEX_BITS-1:0];
			idx_q <= '0;
			next_seq_q <= SEQ_START;
			next_send_q <= 48'd0;
			sent_q <= 32'd0;
			recv_q <= 32'd0;
			fin_q <= 1'b0;
			tcnt_q <= '0;
			pend_q <= 1'b0;
			out_v_q <= 1'b0;
			it_q <= '0;
			res_q <= '0;
			out_q <= '0;
			num_q <= '0;
			den_q <= '0;
			quo_q <= '0;
			lcnt_q <= '0;
		end else begin
			out_v_q <= out_set || (out_v_q && !m_ready);
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == INDEX_BITS'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid && !fin_q) begin
						it_q <= q_item;
						tcnt_q <= '0;
						if (!q_item.command) begin
							state_q <= (limit_ok && q_item.now_ns >= next_send_q) ?
								S_PROBE : S_SW_RD;
						end else begin
							state_q <= S_RP_RD;
						end
					end
				end
				S_PROBE: begin
					if (sent_q != COUNT_MAX) sent_q <= sent_q + 32'd1;
					res_q <= '{KIND_PROBE, next_seq_q, 48'd0, 32'd0, 32'd0, 7'd0, 1'b0};
					next_seq_q <= next_seq_q + 32'd1;
					next_send_q <= nxt_sum[48] ? TIME_MAX : nxt_sum[47:0];
					ret_q <= S_SW_RD;
					state_q <= S_LOSS;
				end
				S_SW_RD: begin
					if (sweep_q == next_idx || tcnt_q == SW'(MAX_SWEEP)) state_q <= S_FIN;
					else state_q <= S_SW_WAIT;
				end
				S_SW_WAIT: state_q <= S_SW_TEST;
				S_SW_TEST: begin
					if (rf_rd_q) begin
						sweep_q <= sweep_q + 1'b1;
						state_q <= S_SW_RD;
					end else if (!exp_sum[48] && it_q.now_ns >= exp_sum[47:0]) begin
						res_q <= '{KIND_TIMEOUT, 32'(sweep_q), 48'd0, 32'd0, 32'd0,
							7'd0, 1'b0};
						sweep_q <= sweep_q + 1'b1;
						tcnt_q <= tcnt_q + 1'b1;
						ret_q <= S_SW_RD;
						state_q <= S_LOSS;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_now) begin
						fin_q <= 1'b1;
						res_q <= '{KIND_FINISHED, 32'd0, 48'd0, 32'd0, 32'd0, 7'd0, 1'b0};
						ret_q <= S_IDLE;
						state_q <= S_LOSS;
					end else begin
						state_q <= S_IDLE;
						if (pend_q) begin
							out_q.last <= 1'b1;
							pend_q <= 1'b0;
						end
					end
				end
				S_RP_RD: state_q <= S_RP_WAIT;
				S_RP_WAIT: state_q <= S_RP_TEST;
				S_RP_TEST: begin
					if (rf_rd_q) begin
						state_q <= S_IDLE;
					end else begin
						if (recv_q != COUNT_MAX) recv_q <= recv_q + 32'd1;
						res_q <= '{((it_q.flags & FLAG_SYN) != 8'd0 &&
						           (it_q.flags & FLAG_ACK) != 8'd0) ? KIND_SYNACK : KIND_RST,
							32'(ack_m1[INDEX_BITS-1:0]),
							(st_rd_q != 48'd0 && it_q.now_ns >= st_rd_q) ?
								it_q.now_ns - st_rd_q : 48'd0,
							32'd0, 32'd0, 7'd0, 1'b1};
						ret_q <= S_IDLE;
						state_q <= S_LOSS;
					end
				end
				S_LOSS: begin
					// Restoring division over seven quotient bits.
					if (lcnt_q == 3'd0) begin
						den_q <= sent_q;
						num_q <= (sent_q == 32'd0 || recv_q >= sent_q) ? 39'd0 :
							39'(({7'd0, sent_q - recv_q} * 39'd100));
						quo_q <= '0;
						lcnt_q <= 3'd1;
					end else begin
						if (den_q != 32'd0 && num_q >= (trial >> lcnt_q)) begin
							num_q <= num_q - (trial >> lcnt_q);
							quo_q <= quo_q | (7'd1 << (3'd7 - lcnt_q));
						end
						if (lcnt_q == 3'd7) begin
							lcnt_q <= 3'd0;
							state_q <= S_EMIT;
						end else begin
							lcnt_q <= lcnt_q + 3'd1;
						end
					end
				end
				S_EMIT: begin
					if (pend_q) begin
						pend_q <= 1'b0;
					end else if (!out_v_q || m_ready) begin
						out_q <= '{res_q.kind, res_q.sequence_res, res_q.rtt_ns, sent_q,
							recv_q, quo_q, ret_q == S_IDLE};
						if (ret_q != S_IDLE) pend_q <= 1'b1;
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/syn_probe_tracker_unit.sv
// Top level of the SYN probe tracker: configuration, front, queue and back.
//
//  channel  direction  contents
//  s_axis   in         tdata: command, now_ns, reply_src_port, reply_dst_port,
//                      reply_ack, reply_flags
//  m_axis   out        tdata: kind, sequence_res, rtt_ns, sent_total, received_total,
//                      loss_percent; tlast: last
//  cfg      in         index and 48-bit value of one register
//
// A tick starts, sends a probe when one is due, sweeps entries for timeouts and closes;
// each result then runs the loss division and passes to the output.
// A reply reads its entry and, unless that entry is already resolved, yields a result.
// Items pass through the front register and the queue; the back takes one item at a time.
// After reset a clearing pass over all 2^INDEX_BITS entries runs before items are taken.
// Results wait in one output register; the back stalls until it is free.
`timescale 1ns / 1ps
module syn_probe_tracker_unit
	import spt_pkg::*;
#(
	parameter int INDEX_BITS = 10,
	parameter int MAX_SWEEP  = 62
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// command, now_ns, reply_src_port, reply_dst_port, reply_ack, reply_flags; 7 pad bits
	input  logic [127:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// kind, sequence_res, rtt_ns, sent_total, received_total, loss_percent; 6 pad bits
	output logic [159:0] m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [47:0]  cfg_data
);
	logic [15:0] local_port_q, remote_port_q;
	logic [31:0] probe_limit_q;
	logic [47:0] timeout_q, interval_q;
	item_t   s_item, f_item, b_item;
	logic    f_valid, f_ready, b_valid, b_ready, busy;
	result_t res;

	assign cfg_ready = !busy;
	assign s_item = '{s_axis_tdata[0], s_axis_tdata[48:1], s_axis_tdata[64:49],
		s_axis_tdata[80:65], s_axis_tdata[112:81], s_axis_tdata[120:113]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_port_q <= 16'd1024;
			remote_port_q <= 16'd1;
			probe_limit_q <= 32'd0;
			timeout_q <= 48'd1000000000;
			interval_q <= 48'd1000000000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOCAL_PORT:  local_port_q <= cfg_data[15:0];
				REG_REMOTE_PORT: remote_port_q <= cfg_data[15:0];
				REG_PROBE_LIMIT: probe_limit_q <= cfg_data[31:0];
				REG_TIMEOUT:     timeout_q <= cfg_data;
				REG_INTERVAL:    interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	spt_front u_front (
		.clk, .arst_n,
		.s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_item,
		.local_port(local_port_q), .remote_port(remote_port_q),
		.q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
	);

	spt_queue u_queue (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
		.out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
	);

	spt_back #(.INDEX_BITS(INDEX_BITS), .MAX_SWEEP(MAX_SWEEP)) u_back (
		.clk, .arst_n,
		.q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
		.probe_limit(probe_limit_q), .timeout_val(timeout_q), .interval_val(interval_q),
		.busy, .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_res(res)
	);

	assign m_axis_tdata = {6'd0, res.loss_percent, res.received_total,
		res.sent_total, res.rtt_ns, res.sequence_res, res.kind};
	assign m_axis_tlast = res.last;
endmodule
